// ===== sv/absc_pkg.sv =====
// ----------------------------------------------------------------------------
// absc_pkg
// Shared types and constants of the ambient brightness slew controller.
// ----------------------------------------------------------------------------
package absc_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TIME_W     = 32;
    localparam int DUTY_W     = 8;
    localparam int FRAC_W     = 9;
    localparam int PROD_W     = 19;

    localparam logic [CFG_DATA_W-1:0] RST_ADC_DARK     = 16'd100;
    localparam logic [CFG_DATA_W-1:0] RST_ADC_BRIGHT   = 16'd3000;
    localparam logic [DUTY_W-1:0]     RST_DUTY_FLOOR   = 8'd20;
    localparam logic [DUTY_W-1:0]     RST_DUTY_CEIL    = 8'd255;
    localparam logic [DUTY_W-1:0]     RST_MAX_STEP     = 8'd8;
    localparam logic [15:0]           RST_PERIOD_MS    = 16'd200;
    localparam logic [DUTY_W-1:0]     RST_DEFAULT_DUTY = 8'd128;

    // Q8 one
    localparam logic [FRAC_W-1:0]     FRAC_ONE         = 9'd256;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ADC_DARK     = 3'd0,
        REG_ADC_BRIGHT   = 3'd1,
        REG_DUTY_FLOOR   = 3'd2,
        REG_DUTY_CEIL    = 3'd3,
        REG_MAX_STEP     = 3'd4,
        REG_PERIOD_MS    = 3'd5,
        REG_DEFAULT_DUTY = 3'd6
    } reg_idx_t;

    typedef enum logic [0:0] {
        KIND_TICK = 1'b0,
        KIND_AUTO = 1'b1
    } item_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_MUL,
        ST_TGT,
        ST_SLEW,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic auto_set;
        logic auto_clr;
        logic take;
        logic div_start;
        logic tgt_floor;
        logic mul;
        logic tgt;
        logic slew;
        logic out_load;
    } absc_cmd_t;

    typedef struct packed {
        logic kind;
        logic auto_on;
        logic sample_due;
        logic span_zero;
        logic div_done;
        logic out_free;
    } absc_sts_t;

endpackage

// ===== sv/absc_div.sv =====
// ----------------------------------------------------------------------------
// absc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module absc_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg,  rem_next;
    logic [NUM_W-1:0] quo_reg,  quo_next;
    logic [DEN_W-1:0] den_reg,  den_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ===== sv/absc_dp.sv =====
// ----------------------------------------------------------------------------
// absc_dp
// Datapath: configuration registers, state, curve mapping, slew and output.
// ----------------------------------------------------------------------------
module absc_dp #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [absc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [absc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              in_kind,
    input  logic [absc_pkg::TIME_W-1:0]       in_now,
    input  logic [SAMPLE_BITS-1:0]            in_sample,
    input  logic                              in_auto_on,
    input  absc_pkg::absc_cmd_t               cmd,
    output absc_pkg::absc_sts_t               sts,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [absc_pkg::DUTY_W-1:0]       out_duty,
    output logic                              out_written
);

    localparam int SB    = SAMPLE_BITS;
    localparam int NUM_W = SAMPLE_BITS + 8;
    localparam int DW    = absc_pkg::DUTY_W;
    localparam int PW    = absc_pkg::PROD_W;

    // configuration
    logic [SB-1:0] adc_dark_reg;
    logic [SB-1:0] adc_bright_reg;
    logic [DW-1:0] duty_floor_reg;
    logic [DW-1:0] duty_ceil_reg;
    logic [DW-1:0] max_step_reg;
    logic [15:0]   period_reg;
    logic [DW-1:0] default_duty_reg;

    // state
    logic [DW-1:0]                 duty_level_reg;
    logic                          auto_reg;
    logic [absc_pkg::TIME_W-1:0]   last_time_reg;

    // item
    logic                          kind_reg;
    logic [absc_pkg::TIME_W-1:0]   now_reg;
    logic [SB-1:0]                 sample_reg;
    logic                          on_reg;
    logic                          written_reg;

    // work
    logic signed [PW-1:0]          prod_reg, prod_next;
    logic [DW-1:0]                 target_reg;
    logic                          out_valid_reg;
    logic [DW-1:0]                 out_duty_reg;
    logic                          out_written_reg;

    logic [absc_pkg::TIME_W-1:0]   elapsed;
    logic signed [SB:0]            diff, diff_neg, span, span_neg;
    logic [SB-1:0]                 diff_mag, span_mag;
    logic [NUM_W-1:0]              quot;
    logic                          div_done;
    logic [absc_pkg::FRAC_W-1:0]   frac;
    logic signed [absc_pkg::FRAC_W:0] frac_s;
    logic signed [DW:0]            dspan;
    logic signed [PW-1:0]          prod_adj, prod_q;
    logic [PW-1:0]                 tgt_sum;
    logic [DW-1:0]                 slew_up, slew_dn, duty_slewed;

    assign elapsed  = now_reg - last_time_reg;

    assign diff     = $signed({1'b0, sample_reg}) - $signed({1'b0, adc_dark_reg});
    assign diff_neg = -diff;
    assign diff_mag = diff[SB] ? diff_neg[SB-1:0] : diff[SB-1:0];
    assign span     = $signed({1'b0, adc_bright_reg}) - $signed({1'b0, adc_dark_reg});
    assign span_neg = -span;
    assign span_mag = span[SB] ? span_neg[SB-1:0] : span[SB-1:0];

    absc_div #(
        .NUM_W (NUM_W),
        .DEN_W (SB)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   ({diff_mag, 8'd0}),
        .den   (span_mag),
        .done  (div_done),
        .quot  (quot)
    );

    // Opposite signs truncate to zero or below; clamp to 0..256.
    always_comb
    begin
        if (diff[SB] ^ span[SB])
            frac = '0;
        else if (quot > NUM_W'(absc_pkg::FRAC_ONE))
            frac = absc_pkg::FRAC_ONE;
        else
            frac = quot[absc_pkg::FRAC_W-1:0];
    end

    assign frac_s    = $signed({1'b0, frac});
    assign dspan     = $signed({1'b0, duty_ceil_reg}) - $signed({1'b0, duty_floor_reg});
    assign prod_next = frac_s * dspan;

    // truncating divide by 256
    assign prod_adj  = prod_reg[PW-1] ? (prod_reg + PW'(255)) : prod_reg;
    assign prod_q    = prod_adj >>> 8;
    assign tgt_sum   = PW'(duty_floor_reg) + prod_q;

    assign slew_up   = target_reg - duty_level_reg;
    assign slew_dn   = duty_level_reg - target_reg;

    always_comb
    begin
        if (duty_level_reg == target_reg)
            duty_slewed = duty_level_reg;
        else if (duty_level_reg < target_reg)
            duty_slewed = (slew_up <= max_step_reg) ? target_reg
                                                    : duty_level_reg + max_step_reg;
        else
            duty_slewed = (slew_dn <= max_step_reg) ? target_reg
                                                    : duty_level_reg - max_step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adc_dark_reg     <= absc_pkg::RST_ADC_DARK[SB-1:0];
            adc_bright_reg   <= absc_pkg::RST_ADC_BRIGHT[SB-1:0];
            duty_floor_reg   <= absc_pkg::RST_DUTY_FLOOR;
            duty_ceil_reg    <= absc_pkg::RST_DUTY_CEIL;
            max_step_reg     <= absc_pkg::RST_MAX_STEP;
            period_reg       <= absc_pkg::RST_PERIOD_MS;
            default_duty_reg <= absc_pkg::RST_DEFAULT_DUTY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                absc_pkg::REG_ADC_DARK:     adc_dark_reg     <= cfg_wdata[SB-1:0];
                absc_pkg::REG_ADC_BRIGHT:   adc_bright_reg   <= cfg_wdata[SB-1:0];
                absc_pkg::REG_DUTY_FLOOR:   duty_floor_reg   <= cfg_wdata[DW-1:0];
                absc_pkg::REG_DUTY_CEIL:    duty_ceil_reg    <= cfg_wdata[DW-1:0];
                absc_pkg::REG_MAX_STEP:     max_step_reg     <= cfg_wdata[DW-1:0];
                absc_pkg::REG_PERIOD_MS:    period_reg       <= cfg_wdata[15:0];
                absc_pkg::REG_DEFAULT_DUTY: default_duty_reg <= cfg_wdata[DW-1:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_level_reg  <= absc_pkg::RST_DEFAULT_DUTY;
            auto_reg        <= 1'b1;
            last_time_reg   <= '0;
            written_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                written_reg <= 1'b0;
            if (cmd.auto_set)
            begin
                auto_reg      <= 1'b1;
                last_time_reg <= '0;
            end
            if (cmd.auto_clr)
            begin
                auto_reg       <= 1'b0;
                duty_level_reg <= default_duty_reg;
                written_reg    <= 1'b1;
            end
            if (cmd.take)
                last_time_reg <= now_reg;
            if (cmd.slew)
            begin
                duty_level_reg <= duty_slewed;
                written_reg    <= 1'b1;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= in_kind;
            now_reg    <= in_now;
            sample_reg <= in_sample;
            on_reg     <= in_auto_on;
        end
        if (cmd.mul)
            prod_reg <= prod_next;
        if (cmd.tgt_floor)
            target_reg <= duty_floor_reg;
        else if (cmd.tgt)
            target_reg <= tgt_sum[DW-1:0];
        if (cmd.out_load)
        begin
            out_duty_reg    <= duty_level_reg;
            out_written_reg <= written_reg;
        end
    end

    assign sts.kind       = kind_reg;
    assign sts.auto_on    = on_reg;
    assign sts.sample_due = auto_reg && (elapsed >= absc_pkg::TIME_W'(period_reg));
    assign sts.span_zero  = (span_mag == '0);
    assign sts.div_done   = div_done;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_duty    = out_duty_reg;
    assign out_written = out_written_reg;

endmodule

// ===== sv/absc_ctrl.sv =====
// ----------------------------------------------------------------------------
// absc_ctrl
// Sequencer: steps one item through decision, divide, scale, slew and output.
// ----------------------------------------------------------------------------
module absc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  absc_pkg::absc_sts_t sts,
    output absc_pkg::absc_cmd_t cmd
);

    absc_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            absc_pkg::ST_IDLE:
                if (in_valid)
                    state_next = absc_pkg::ST_DECIDE;
            absc_pkg::ST_DECIDE:
                if (sts.kind == absc_pkg::KIND_TICK && sts.sample_due)
                    state_next = sts.span_zero ? absc_pkg::ST_SLEW : absc_pkg::ST_DIV;
                else
                    state_next = absc_pkg::ST_OUT;
            absc_pkg::ST_DIV:
                if (sts.div_done)
                    state_next = absc_pkg::ST_MUL;
            absc_pkg::ST_MUL:
                state_next = absc_pkg::ST_TGT;
            absc_pkg::ST_TGT:
                state_next = absc_pkg::ST_SLEW;
            absc_pkg::ST_SLEW:
                state_next = absc_pkg::ST_OUT;
            absc_pkg::ST_OUT:
                if (sts.out_free)
                    state_next = absc_pkg::ST_IDLE;
            default:
                state_next = absc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            absc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            absc_pkg::ST_DECIDE:
            begin
                if (sts.kind == absc_pkg::KIND_AUTO)
                begin
                    cmd.auto_set = sts.auto_on;
                    cmd.auto_clr = !sts.auto_on;
                end
                else if (sts.sample_due)
                begin
                    cmd.take      = 1'b1;
                    cmd.tgt_floor = sts.span_zero;
                    cmd.div_start = !sts.span_zero;
                end
            end
            absc_pkg::ST_DIV:
                ;
            absc_pkg::ST_MUL:
                cmd.mul = 1'b1;
            absc_pkg::ST_TGT:
                cmd.tgt = 1'b1;
            absc_pkg::ST_SLEW:
                cmd.slew = 1'b1;
            absc_pkg::ST_OUT:
                cmd.out_load = sts.out_free;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= absc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== sv/ambient_brightness_slew_controller_core.sv =====
// ----------------------------------------------------------------------------
// ambient_brightness_slew_controller_core
// Auto-brightness from ambient light with a per-sample slew limit.
// ----------------------------------------------------------------------------
// Each input transfer is a tick (time plus light sample) or an auto mode
// request, and yields exactly one output transfer with the kept duty and a
// written flag. An item with no sample taken goes from the decision straight
// to the output register; on a zero span the target is the duty floor and
// the item is slewed; when a sample is mapped it passes the divide, multiply,
// target and slew states. The restoring divider of the curve fraction, one
// quotient bit per cycle over SAMPLE_BITS + 8 bits, is the longest step. One
// item is in work at a time; a finished result sits in the output register
// while the next item is taken.
module ambient_brightness_slew_controller_core #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [absc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [absc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((absc_pkg::TIME_W + SAMPLE_BITS + 1 + 7) / 8) * 8 - 1:0]
                                              s_tdata,   // now_ms, light_sample, auto_on
    input  logic                              s_tuser,   // kind
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [absc_pkg::DUTY_W-1:0]       m_tdata,   // duty
    output logic                              m_tuser    // duty_written
);

    localparam int SMP_LO  = absc_pkg::TIME_W;
    localparam int ON_BIT  = absc_pkg::TIME_W + SAMPLE_BITS;

    absc_pkg::absc_cmd_t cmd;
    absc_pkg::absc_sts_t sts;

    absc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    absc_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_kind     (s_tuser),
        .in_now      (s_tdata[absc_pkg::TIME_W-1:0]),
        .in_sample   (s_tdata[SMP_LO +: SAMPLE_BITS]),
        .in_auto_on  (s_tdata[ON_BIT]),
        .cmd         (cmd),
        .sts         (sts),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_duty    (m_tdata),
        .out_written (m_tuser)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("output register overwritten");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.span_zero && sts.sample_due)
        else $error("divide started without a valid span");

    a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_tvalid)
        else $error("result lost after load");

endmodule

// ===== tb/tb_ambient_brightness_slew_controller_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ambient_brightness_slew_controller_core
// Self-checking bench for the auto-brightness slew controller.
// ----------------------------------------------------------------------------
// A short scripted sequence runs at reset settings. It is followed by several
// register settings: the extremes, inverted windows, a zero span, a zero step
// and random ones. Under each setting random ticks and auto mode requests are
// sent. Every output transfer is checked in order against the fixed value
// of a script row that gives one, else an in-bench model of the duty curve
// and the slew limit. The sender runs in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module tb_ambient_brightness_slew_controller_core;

    localparam int SAMPLE_BITS = 12;
    localparam int TDATA_W     = 48;
    localparam int Q8_ONE      = 256;
    localparam int SETTLE      = 40;
    localparam int LIMIT       = 1000000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 200;
    localparam int SCRIPT_LEN  = 20;
    localparam int LONG_HOLD   = 400;
    localparam int MAX_PRINTS  = 100;

    localparam logic [absc_pkg::CFG_ADDR_W-1:0] REG_NONE = 3'd7;

    localparam int RX_READY  = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_SPARSE = 2;

    typedef struct packed {
        absc_pkg::item_kind_t   kind;
        logic [31:0]            now_ms;
        logic [SAMPLE_BITS-1:0] light;
        logic                   auto_on;
    } light_item_t;

    typedef struct packed {
        logic [7:0] duty;
        logic       written;
    } duty_result_t;

    typedef struct packed {
        absc_pkg::item_kind_t   kind;
        logic [31:0]            now_ms;
        logic [SAMPLE_BITS-1:0] light;
        logic                   auto_on;
        logic                   fixed;
        logic [7:0]             duty;
        logic                   written;
    } script_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [absc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [absc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [TDATA_W-1:0]              s_tdata = '0;
    logic                            s_tuser = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [absc_pkg::DUTY_W-1:0]     m_tdata;
    logic                            m_tuser;

    // in-bench copy of the registers and state
    logic [SAMPLE_BITS-1:0] cfg_dark;
    logic [SAMPLE_BITS-1:0] cfg_bright;
    logic [7:0]             cfg_floor;
    logic [7:0]             cfg_ceil;
    logic [7:0]             cfg_step;
    logic [15:0]            cfg_period;
    logic [7:0]             cfg_default;
    logic [7:0]             duty_level;
    logic                   auto_en;
    logic [31:0]            last_ms;

    duty_result_t pending_duty[$];

    int errors     = 0;
    int n_items    = 0;
    int n_checked  = 0;
    int n_samples  = 0;
    int n_settings = 0;
    int cycles     = 0;
    int burst_left = 0;
    int hold_reqs  = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int rx_mode    = RX_READY;
    int rx_left    = 0;

    script_row_t script [SCRIPT_LEN] = '{
        '{absc_pkg::KIND_TICK, 32'd0,         12'd0,    1'b0, 1'b1, 8'd128, 1'b0},
        '{absc_pkg::KIND_TICK, 32'd200,       12'd4095, 1'b0, 1'b1, 8'd136, 1'b1},
        '{absc_pkg::KIND_TICK, 32'd300,       12'd4095, 1'b0, 1'b1, 8'd136, 1'b0},
        '{absc_pkg::KIND_TICK, 32'd400,       12'd2000, 1'b1, 1'b0, 8'd0,   1'b0},
        '{absc_pkg::KIND_AUTO, 32'd0,         12'd0,    1'b0, 1'b1, 8'd128, 1'b1},
        '{absc_pkg::KIND_TICK, 32'd5000,      12'd4095, 1'b0, 1'b1, 8'd128, 1'b0},
        '{absc_pkg::KIND_AUTO, 32'hFFFF_FFFF, 12'd4095, 1'b0, 1'b1, 8'd128, 1'b1},
        '{absc_pkg::KIND_AUTO, 32'd0,         12'd0,    1'b1, 1'b1, 8'd128, 1'b0},
        '{absc_pkg::KIND_TICK, 32'd199,       12'd4095, 1'b0, 1'b1, 8'd128, 1'b0},
        '{absc_pkg::KIND_TICK, 32'd200,       12'd0,    1'b0, 1'b1, 8'd120, 1'b1},
        '{absc_pkg::KIND_TICK, 32'hFFFF_FFFF, 12'd0,    1'b1, 1'b1, 8'd112, 1'b1},
        '{absc_pkg::KIND_TICK, 32'd199,       12'd4095, 1'b0, 1'b1, 8'd120, 1'b1},
        '{absc_pkg::KIND_TICK, 32'd398,       12'd4095, 1'b0, 1'b1, 8'd120, 1'b0},
        '{absc_pkg::KIND_TICK, 32'd399,       12'd100,  1'b0, 1'b0, 8'd0,   1'b0},
        '{absc_pkg::KIND_TICK, 32'd599,       12'd3000, 1'b0, 1'b0, 8'd0,   1'b0},
        '{absc_pkg::KIND_TICK, 32'd799,       12'd1550, 1'b0, 1'b0, 8'd0,   1'b0},
        '{absc_pkg::KIND_TICK, 32'd999,       12'd4095, 1'b1, 1'b0, 8'd0,   1'b0},
        '{absc_pkg::KIND_AUTO, 32'hFFFF_FFFF, 12'd4095, 1'b1, 1'b0, 8'd0,   1'b0},
        '{absc_pkg::KIND_TICK, 32'd200,       12'd4095, 1'b0, 1'b0, 8'd0,   1'b0},
        '{absc_pkg::KIND_AUTO, 32'h5555_AAAA, 12'd2730, 1'b0, 1'b1, 8'd128, 1'b1}
    };

    // dark, bright, floor, ceil, step, period, default
    int unsigned fixed_plan [6][7] = '{
        '{0,    4095, 0,   255, 255, 0,     0},
        '{4095, 0,    255, 0,   1,   65535, 255},
        '{2000, 2000, 77,  200, 16,  50,    10},
        '{500,  3500, 30,  220, 0,   10,    99},
        '{4095, 4095, 255, 255, 255, 1,     255},
        '{0,    0,    0,   0,   0,   0,     0}
    };

    ambient_brightness_slew_controller_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // now_ms, light_sample, auto_on
        .s_tuser   (s_tuser),   // kind
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // duty
        .m_tuser   (m_tuser)    // duty_written
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_duty.size());
            $display("tb_ambient_brightness_slew_controller_core: errors");
            $finish;
        end
    end

    function automatic void backlight_reset();
        cfg_dark    = absc_pkg::RST_ADC_DARK[SAMPLE_BITS-1:0];
        cfg_bright  = absc_pkg::RST_ADC_BRIGHT[SAMPLE_BITS-1:0];
        cfg_floor   = absc_pkg::RST_DUTY_FLOOR;
        cfg_ceil    = absc_pkg::RST_DUTY_CEIL;
        cfg_step    = absc_pkg::RST_MAX_STEP;
        cfg_period  = absc_pkg::RST_PERIOD_MS;
        cfg_default = absc_pkg::RST_DEFAULT_DUTY;
        duty_level  = absc_pkg::RST_DEFAULT_DUTY;
        auto_en     = 1'b1;
        last_ms     = '0;
    endfunction

    function automatic void apply_reg_write(logic [absc_pkg::CFG_ADDR_W-1:0] idx,
                                            logic [absc_pkg::CFG_DATA_W-1:0] d);
        case (idx)
            absc_pkg::REG_ADC_DARK:     cfg_dark    = d[SAMPLE_BITS-1:0];
            absc_pkg::REG_ADC_BRIGHT:   cfg_bright  = d[SAMPLE_BITS-1:0];
            absc_pkg::REG_DUTY_FLOOR:   cfg_floor   = d[7:0];
            absc_pkg::REG_DUTY_CEIL:    cfg_ceil    = d[7:0];
            absc_pkg::REG_MAX_STEP:     cfg_step    = d[7:0];
            absc_pkg::REG_PERIOD_MS:    cfg_period  = d[15:0];
            absc_pkg::REG_DEFAULT_DUTY: cfg_default = d[7:0];
            default: ;
        endcase
    endfunction

    function automatic int reg_width(logic [absc_pkg::CFG_ADDR_W-1:0] idx);
        case (idx)
            absc_pkg::REG_ADC_DARK, absc_pkg::REG_ADC_BRIGHT: return SAMPLE_BITS;
            absc_pkg::REG_PERIOD_MS:                          return 16;
            REG_NONE:                                         return 0;
            default:                                          return 8;
        endcase
    endfunction

    // linear map of the light window onto the duty window via a Q8 fraction
    function automatic logic [7:0] curve_target(logic [SAMPLE_BITS-1:0] light);
        int span;
        int frac;
        int dspan;
        span = int'(cfg_bright) - int'(cfg_dark);
        if (span == 0)
            return cfg_floor;
        frac = ((int'(light) - int'(cfg_dark)) * Q8_ONE) / span;
        if (frac < 0)
            frac = 0;
        if (frac > Q8_ONE)
            frac = Q8_ONE;
        dspan = int'(cfg_ceil) - int'(cfg_floor);
        return 8'(int'(cfg_floor) + (frac * dspan) / Q8_ONE);
    endfunction

    function automatic logic [7:0] slew_toward(logic [7:0] cur, logic [7:0] aim);
        if (cur == aim)
            return cur;
        if (cur < aim)
            return (aim - cur <= cfg_step) ? aim : cur + cfg_step;
        return (cur - aim <= cfg_step) ? aim : cur - cfg_step;
    endfunction

    function automatic duty_result_t advance_backlight(light_item_t it);
        duty_result_t res;
        res.written = 1'b0;
        if (it.kind == absc_pkg::KIND_TICK)
        begin
            if (auto_en && (it.now_ms - last_ms) >= 32'(cfg_period))
            begin
                last_ms     = it.now_ms;
                duty_level  = slew_toward(duty_level, curve_target(it.light));
                res.written = 1'b1;
            end
        end
        else if (it.auto_on)
        begin
            auto_en = 1'b1;
            last_ms = '0;
        end
        else
        begin
            auto_en     = 1'b0;
            duty_level  = cfg_default;
            res.written = 1'b1;
        end
        res.duty = duty_level;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        if (errors < MAX_PRINTS)
            $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic send_item(light_item_t it, logic use_fixed, duty_result_t fixed_res);
        int gap;
        duty_result_t res;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= TDATA_W'({it.auto_on, it.light, it.now_ms});
        do @(posedge clk); while (!s_tready);
        res = advance_backlight(it);
        if (use_fixed)
            res = fixed_res;
        pending_duty.push_back(res);
        n_items++;
        if (it.kind == absc_pkg::KIND_TICK && res.written)
            n_samples++;
    endtask

    // drain the block before touching the registers
    task automatic go_idle();
        s_tvalid <= 1'b0;
        while (pending_duty.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_settings(int unsigned vals [7]);
        int w;
        logic [absc_pkg::CFG_DATA_W-1:0] d;
        logic [absc_pkg::CFG_DATA_W-1:0] keep;
        for (int r = 0; r <= 7; r++)
        begin
            w = reg_width(absc_pkg::CFG_ADDR_W'(r));
            keep = (w >= absc_pkg::CFG_DATA_W) ? '1
                                               : absc_pkg::CFG_DATA_W'((1 << w) - 1);
            d = (r < 7) ? absc_pkg::CFG_DATA_W'(vals[r])
                        : absc_pkg::CFG_DATA_W'($urandom);
            // junk above the register width must be dropped
            d = (d & keep) | (absc_pkg::CFG_DATA_W'($urandom) & ~keep);
            cfg_we    <= 1'b1;
            cfg_addr  <= absc_pkg::CFG_ADDR_W'(r);
            cfg_wdata <= d;
            @(posedge clk);
            apply_reg_write(absc_pkg::CFG_ADDR_W'(r), d);
        end
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_reqs != hold_seen)
        begin
            hold_seen = hold_reqs;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(RX_READY, RX_SPARSE);
                rx_left = $urandom_range(16, 200);
            end
            rx_left--;
            case (rx_mode)
                RX_READY:  m_tready <= 1'b1;
                RX_RANDOM: m_tready <= ($urandom_range(0, 2) != 0);
                default:   m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        duty_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_duty.size() == 0)
                report_mismatch("result with nothing expected, duty", m_tdata, 8'd0);
            else
            begin
                want = pending_duty.pop_front();
                n_checked++;
                if (m_tdata !== want.duty)
                    report_mismatch("duty", m_tdata, want.duty);
                if (m_tuser !== want.written)
                    report_mismatch("duty_written", 8'(m_tuser), 8'(want.written));
            end
        end
    end

    initial
    begin
        light_item_t  it;
        duty_result_t fixed_res;
        int unsigned  vals [7];
        logic [31:0]  wall_ms;
        int           pick;
        backlight_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            it.kind         = script[i].kind;
            it.now_ms       = script[i].now_ms;
            it.light        = script[i].light;
            it.auto_on      = script[i].auto_on;
            fixed_res.duty    = script[i].duty;
            fixed_res.written = script[i].written;
            send_item(it, script[i].fixed, fixed_res);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            go_idle();
            if (ph < 6)
                vals = fixed_plan[ph];
            else
            begin
                vals[0] = $urandom_range(0, 4095);
                vals[1] = ($urandom_range(0, 3) == 0) ? vals[0] : $urandom_range(0, 4095);
                vals[2] = $urandom_range(0, 255);
                vals[3] = $urandom_range(0, 255);
                vals[4] = $urandom_range(0, 40);
                vals[5] = $urandom_range(0, 500);
                vals[6] = $urandom_range(0, 255);
            end
            write_settings(vals);
            wall_ms = (ph % 4 == 2) ? 32'hFFFF_FFFF - $urandom_range(0, 200000)
                                    : $urandom_range(0, 1000);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                begin
                    if (ph == 1 || ph == 5)
                    begin
                        hold_reqs++;
                        burst_left = 60;
                    end
                    if (ph == 3)
                        go_idle();
                end
                pick       = $urandom_range(0, 99);
                it.auto_on = 1'($urandom_range(0, 1));
                it.light   = SAMPLE_BITS'($urandom);
                it.now_ms  = $urandom;
                if (pick < 84)
                begin
                    it.kind = absc_pkg::KIND_TICK;
                    if (pick < 6)
                        wall_ms = $urandom;
                    else
                        wall_ms += $urandom_range(0, int'(cfg_period) + int'(cfg_period) / 2 + 2);
                    it.now_ms = wall_ms;
                    if ($urandom_range(0, 3) == 0)
                    begin
                        case ($urandom_range(0, 5))
                            0: it.light = cfg_dark;
                            1: it.light = cfg_bright;
                            2: it.light = cfg_dark - 1'b1;
                            3: it.light = cfg_bright + 1'b1;
                            4: it.light = '0;
                            default: it.light = '1;
                        endcase
                    end
                end
                else
                begin
                    it.kind    = absc_pkg::KIND_AUTO;
                    it.auto_on = (pick < 96);
                end
                send_item(it, 1'b0, '0);
            end
        end

        go_idle();
        if (pending_duty.size() != 0)
            report_mismatch("results never delivered, count", 8'(pending_duty.size()), 8'd0);
        $display("run: %0d transfers in, %0d checked, %0d light samples mapped",
                 n_items, n_checked, n_samples);
        $display("run: %0d register settings incl. extremes, inverted and zero windows",
                 n_settings);
        if (errors == 0)
            $display("tb_ambient_brightness_slew_controller_core: clean");
        else
            $display("tb_ambient_brightness_slew_controller_core: errors");
        $finish;
    end

endmodule
